@@ hdl/bsl_pkg.sv @@
// Shared constants and types for the bounded substring locator.
// Holds the register index codes and the parameter defaults; no dependencies.
package bsl_pkg;

    localparam int PATTERN_MAX_DEF   = 8;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LENGTH_W    = 4;
    localparam int LIMIT_W     = 16;
    localparam int TEXT_W      = 8;
    localparam int FLAGS_W     = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_SEARCH_LIMIT   = 2'd2
    } cfg_index_t;

endpackage

@@ hdl/bounded_substring_locator_core.sv @@
// Bounded substring locator: streams text bytes, compares a sliding window
// against a configured pattern and reports match positions per string.
// Depends on bsl_pkg.
//
//  channel | direction | beat contents
//  --------+-----------+------------------------------------------------------
//  s_*     | in        | s_tdata: text_byte (0 ends the string)
//  m_*     | out       | m_tdata: first_start, first_end, last_end, scanned_count
//          |           | m_tuser: first_found, last_found
//  cfg_*   | in        | cfg_index selects register, cfg_data is the value
//
// One text byte per cycle while s_tready is high; the window compare and position update sit between
// the per-string state registers and the result register.
// The result register loads on the terminating beat and holds until taken;
// input is accepted whenever the result register is empty or being drained.
// rst_n clears string state, result register, pattern, length; limit to all ones.
module bounded_substring_locator_core
    import bsl_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int DATA_W       = ((4 * POSITION_BITS + 2 + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TEXT_W-1:0]      s_tdata,   // [7:0] text_byte

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // from bit 0 up: first_start, first_end, last_end, scanned_count, zero fill
    output logic [DATA_W-1:0]      m_tdata,
    output logic [FLAGS_W-1:0]     m_tuser,   // [0] first_found, [1] last_found

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW     = POSITION_BITS + 1;
    localparam int PW     = PATTERN_MAX * 8;
    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int EXT_W  = (CW + 1 > LIMIT_W) ? CW + 1 : LIMIT_W;
    localparam int USED_W = 4 * POSITION_BITS + 2;

    // configuration
    logic [PW-1:0]       pattern_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // per-string state
    logic [PW-1:0]            window_reg,      window_next;
    logic [CW-1:0]            pos_reg,         pos_next;
    logic                     have_first_reg,  have_first_next;
    logic [POSITION_BITS-1:0] first_start_reg, first_start_next;
    logic [CW-1:0]            last_end_reg,    last_end_next;

    // result register
    logic                     out_valid_reg,   out_valid_next;
    logic [DATA_W-1:0]        out_data_reg,    out_data_next;
    logic [FLAGS_W-1:0]       out_flags_reg,   out_flags_next;

    logic                     in_beat;
    logic                     term_beat;
    logic [LEN_W-1:0]         eff_len;
    logic [PATTERN_MAX:0]     match_vec;
    logic [CW:0]              pos_plus1;
    logic [CW:0]              len_ext;
    logic [CW:0]              start_pos;
    logic                     hit;
    logic [POSITION_BITS-1:0] scanned;
    logic [CW-1:0]            first_end;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign term_beat = in_beat && (s_tdata == '0);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flags_reg;

    // Effective length: clamp to PATTERN_MAX, then cut at the first zero byte.
    always_comb
    begin
        logic [LEN_W-1:0] clamped;
        if (length_reg > LENGTH_W'(PATTERN_MAX))
            clamped = LEN_W'(PATTERN_MAX);
        else
            clamped = LEN_W'(length_reg);
        eff_len = clamped;
        for (int c = PATTERN_MAX - 1; c >= 0; c--)
        begin
            if ((LEN_W'(c) < clamped) && (pattern_reg[8*c +: 8] == 8'd0))
                eff_len = LEN_W'(c);
        end
    end

    // Newest byte sits in the low byte of the window.
    assign window_next = PW'({window_reg, s_tdata});

    // One compare row per candidate length; pattern char c lines up with
    // window byte len-1-c.
    always_comb
    begin
        match_vec = '0;
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            logic ok;
            ok = 1'b1;
            for (int c = 0; c < l; c++)
            begin
                if (pattern_reg[8*c +: 8] != window_next[8*(l-1-c) +: 8])
                    ok = 1'b0;
            end
            match_vec[l] = ok;
        end
    end

    assign pos_plus1 = {1'b0, pos_reg} + (CW+1)'(1);
    assign len_ext   = (CW+1)'(eff_len);
    assign start_pos = pos_plus1 - len_ext;
    assign hit = (eff_len != '0) && (pos_plus1 >= len_ext)
              && (EXT_W'(start_pos) < EXT_W'(limit_reg)) && match_vec[eff_len];

    always_comb
    begin
        if (EXT_W'(pos_reg) < EXT_W'(limit_reg))
            scanned = pos_reg[POSITION_BITS-1:0];
        else
            scanned = POSITION_BITS'(limit_reg);
    end

    assign first_end = {1'b0, first_start_reg} + CW'(eff_len);

    always_comb
    begin
        pos_next         = pos_reg;
        have_first_next  = have_first_reg;
        first_start_next = first_start_reg;
        last_end_next    = last_end_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_flags_next   = out_flags_reg;

        if (term_beat)
        begin
            pos_next         = '0;
            have_first_next  = 1'b0;
            first_start_next = '0;
            last_end_next    = '0;
            out_valid_next   = 1'b1;
            if (eff_len == '0)
            begin
                out_flags_next = '0;
                out_data_next  = DATA_W'({scanned, {(3*POSITION_BITS+2){1'b0}}});
            end
            else if (have_first_reg)
            begin
                out_flags_next = 2'b11;
                out_data_next  = DATA_W'({scanned, last_end_reg, first_end,
                                          first_start_reg});
            end
            else
            begin
                out_flags_next = '0;
                out_data_next  = DATA_W'({scanned, CW'(0), CW'(scanned), scanned});
            end
        end
        else if (in_beat)
        begin
            if (hit)
            begin
                if (!have_first_reg)
                begin
                    have_first_next  = 1'b1;
                    first_start_next = start_pos[POSITION_BITS-1:0];
                end
                last_end_next = pos_plus1[CW-1:0];
            end
            if (pos_reg != {CW{1'b1}})
                pos_next = pos_plus1[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= '0;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_reg <= cfg_data[PW-1:0];
                CFG_PATTERN_LENGTH: length_reg  <= cfg_data[LENGTH_W-1:0];
                CFG_SEARCH_LIMIT:   limit_reg   <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            pos_reg         <= '0;
            have_first_reg  <= 1'b0;
            first_start_reg <= '0;
            last_end_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            out_flags_reg   <= '0;
        end
        else
        begin
            if (term_beat)
                window_reg <= '0;
            else if (in_beat)
                window_reg <= window_next;
            pos_reg         <= pos_next;
            have_first_reg  <= have_first_next;
            first_start_reg <= first_start_next;
            last_end_reg    <= last_end_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
            out_flags_reg   <= out_flags_next;
        end
    end

    // checks
    a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        term_beat |=> out_valid_reg)
        else $error("terminating beat did not load a result");

    a_term_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        term_beat |=> (pos_reg == '0) && !have_first_reg)
        else $error("string state not cleared after terminating beat");

    a_no_match_before_text: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) |-> !have_first_reg)
        else $error("match recorded with no text seen");

    a_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_flags_reg[0] == out_flags_reg[1]))
        else $error("first and last found flags differ");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg >> USED_W) == '0)
        else $error("result padding bits not zero");

endmodule
